// ----- rtl/thread_cached_block_allocator_assert.svh -----
// Assertion macros used by the checker file.
`ifndef THREAD_CACHED_BLOCK_ALLOCATOR_ASSERT_SVH
`define THREAD_CACHED_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCBA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcba_pkg.sv -----
`default_nettype none
package tcba_pkg;
    localparam int THREADS      = 8;
    localparam int SMALL_DEPTH  = 20;
    localparam int LARGE_DEPTH  = 10;
    localparam int GLOBAL_DEPTH = 64;
    localparam int MAX_BLOCKS   = 256;

    localparam int TID_W    = 3;
    localparam int HANDLE_W = 8;
    localparam int LEN_W    = 32;
    localparam int SLIM_W   = 16;
    localparam int SCAP_W   = 5;
    localparam int LCAP_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SMALL_ADDR_W  = $clog2(THREADS * SMALL_DEPTH);
    localparam int LARGE_ADDR_W  = $clog2(THREADS * LARGE_DEPTH);
    localparam int GLOBAL_ADDR_W = $clog2(GLOBAL_DEPTH);
    localparam int GCOUNT_W      = $clog2(GLOBAL_DEPTH + 1);
    localparam int POOL_W        = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W         = 7;
    localparam int BLK_W         = TID_W + LEN_W;

    localparam logic [SCAP_W-1:0] SMALL_DEPTH_CAP = SCAP_W'(SMALL_DEPTH);
    localparam logic [LCAP_W-1:0] LARGE_DEPTH_CAP = LCAP_W'(LARGE_DEPTH);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [2:0] ACT_SMALL     = 3'd0;
    localparam logic [2:0] ACT_LOCAL     = 3'd1;
    localparam logic [2:0] ACT_GLOBAL    = 3'd2;
    localparam logic [2:0] ACT_NEW       = 3'd3;
    localparam logic [2:0] ACT_KEPT      = 3'd4;
    localparam logic [2:0] ACT_TO_GLOBAL = 3'd5;
    localparam logic [2:0] ACT_RELEASED  = 3'd6;
    localparam logic [2:0] ACT_IGNORED   = 3'd7;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_NO_HANDLE   = 2'd1;
    localparam logic [1:0] ERR_GLOBAL_FULL = 2'd2;
    localparam logic [1:0] ERR_INVALID     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_CAP   = 2'd2;

    localparam logic [1:0] KIND_ALLOC_SMALL = 2'd0;
    localparam logic [1:0] KIND_ALLOC_LARGE = 2'd1;
    localparam logic [1:0] KIND_FREE_NULL   = 2'd2;
    localparam logic [1:0] KIND_FREE        = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic [TID_W-1:0]    thread_id;
        logic [LEN_W-1:0]    req_size;
        logic                handle_present;
        logic [HANDLE_W-1:0] block_handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [LEN_W-1:0]    out_len;
        logic [2:0]          action;
        logic [1:0]          error_code;
    } rsp_t;

    typedef struct packed {
        logic [SLIM_W-1:0] small_limit;
        logic [SCAP_W-1:0] small_cap;
        logic [LCAP_W-1:0] large_cap;
    } cfg_t;

    typedef struct packed {
        req_t       req;
        logic [1:0] kind;
    } entry_t;

    function automatic logic [SMALL_ADDR_W-1:0] small_addr(input logic [TID_W-1:0] tid,
                                                           input logic [SCAP_W-1:0] idx);
        small_addr = SMALL_ADDR_W'(tid) * SMALL_ADDR_W'(SMALL_DEPTH) + SMALL_ADDR_W'(idx);
    endfunction

    function automatic logic [LARGE_ADDR_W-1:0] large_addr(input logic [TID_W-1:0] tid,
                                                           input logic [LCAP_W-1:0] idx);
        large_addr = LARGE_ADDR_W'(tid) * LARGE_ADDR_W'(LARGE_DEPTH) + LARGE_ADDR_W'(idx);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/tcba_ram.sv -----
`default_nettype none
module tcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- rtl/tcba_front.sv -----
`default_nettype none
module tcba_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcba_pkg::cfg_t  cfg,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire tcba_pkg::req_t  req_word,
    output logic                 q_valid,
    input  wire logic            q_pop,
    output tcba_pkg::entry_t     q_entry
);
    import tcba_pkg::*;

    entry_t     entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    entry_t     incoming;
    logic       push;

    // Sort each word into its class as it arrives.
    always_comb
    begin
        incoming.req = req_word;
        if (req_word.req_type == REQ_ALLOC)
        begin
            incoming.kind = (req_word.req_size <= LEN_W'(cfg.small_limit))
                          ? KIND_ALLOC_SMALL : KIND_ALLOC_LARGE;
        end
        else
        begin
            incoming.kind = req_word.handle_present ? KIND_FREE : KIND_FREE_NULL;
        end
    end

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_entry   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tcba_back.sv -----
`default_nettype none
module tcba_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tcba_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire tcba_pkg::entry_t q_entry,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output tcba_pkg::rsp_t        rsp_word
);
    import tcba_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_SPOP     = 4'd2;
    localparam logic [3:0] ST_SLEN     = 4'd3;
    localparam logic [3:0] ST_SCAN_RD  = 4'd4;
    localparam logic [3:0] ST_SCAN_H   = 4'd5;
    localparam logic [3:0] ST_SCAN_CMP = 4'd6;
    localparam logic [3:0] ST_SHIFT_RD = 4'd7;
    localparam logic [3:0] ST_SHIFT_WR = 4'd8;
    localparam logic [3:0] ST_TAKE     = 4'd9;
    localparam logic [3:0] ST_NEW      = 4'd10;
    localparam logic [3:0] ST_NPOP     = 4'd11;
    localparam logic [3:0] ST_NWR      = 4'd12;
    localparam logic [3:0] ST_FREAD    = 4'd13;
    localparam logic [3:0] ST_DONE     = 4'd14;

    logic [3:0]          state_reg, state_next;
    entry_t              cur_reg, cur_next;
    logic [HANDLE_W-1:0] cand_reg, cand_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                sel_global_reg, sel_global_next;
    logic [2:0]          act_reg, act_next;
    rsp_t                res_reg, res_next;
    rsp_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [MAX_BLOCKS-1:0] live_reg, live_next;
    logic [SCAP_W-1:0]   small_count_reg [THREADS];
    logic [SCAP_W-1:0]   small_count_next [THREADS];
    logic [LCAP_W-1:0]   large_count_reg [THREADS];
    logic [LCAP_W-1:0]   large_count_next [THREADS];
    logic [GCOUNT_W-1:0] global_count_reg, global_count_next;
    logic [POOL_W-1:0]   pool_count_reg, pool_count_next;
    logic [POOL_W-1:0]   fresh_reg, fresh_next;

    logic                    blk_we;
    logic [HANDLE_W-1:0]     blk_waddr, blk_raddr;
    logic [BLK_W-1:0]        blk_wdata, blk_rdata;
    logic                    small_we;
    logic [SMALL_ADDR_W-1:0] small_waddr, small_raddr;
    logic [HANDLE_W-1:0]     small_wdata, small_rdata;
    logic                    large_we;
    logic [LARGE_ADDR_W-1:0] large_waddr, large_raddr;
    logic [HANDLE_W-1:0]     large_wdata, large_rdata;
    logic                     glob_we;
    logic [GLOBAL_ADDR_W-1:0] glob_waddr, glob_raddr;
    logic [HANDLE_W-1:0]      glob_wdata, glob_rdata;
    logic                pool_we;
    logic [HANDLE_W-1:0] pool_waddr, pool_raddr;
    logic [HANDLE_W-1:0] pool_wdata, pool_rdata;

    logic [TID_W-1:0]    tid;
    logic [HANDLE_W-1:0] list_rdata;
    logic [LEN_W-1:0]    blk_len;
    logic [TID_W-1:0]    blk_owner;
    logic [SCAP_W-1:0]   small_cap_eff;
    logic [LCAP_W-1:0]   large_cap_eff;

    tcba_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
        .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .raddr(blk_raddr), .rdata(blk_rdata)
    );
    tcba_ram #(.WIDTH(HANDLE_W), .DEPTH(THREADS * SMALL_DEPTH)) u_small_ram (
        .clk(clk), .we(small_we), .waddr(small_waddr), .wdata(small_wdata),
        .raddr(small_raddr), .rdata(small_rdata)
    );
    tcba_ram #(.WIDTH(HANDLE_W), .DEPTH(THREADS * LARGE_DEPTH)) u_large_ram (
        .clk(clk), .we(large_we), .waddr(large_waddr), .wdata(large_wdata),
        .raddr(large_raddr), .rdata(large_rdata)
    );
    tcba_ram #(.WIDTH(HANDLE_W), .DEPTH(GLOBAL_DEPTH)) u_glob_ram (
        .clk(clk), .we(glob_we), .waddr(glob_waddr), .wdata(glob_wdata),
        .raddr(glob_raddr), .rdata(glob_rdata)
    );
    tcba_ram #(.WIDTH(HANDLE_W), .DEPTH(MAX_BLOCKS)) u_pool_ram (
        .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
        .raddr(pool_raddr), .rdata(pool_rdata)
    );

    assign tid           = cur_reg.req.thread_id;
    assign list_rdata    = sel_global_reg ? glob_rdata : large_rdata;
    assign blk_len       = blk_rdata[LEN_W-1:0];
    assign blk_owner     = blk_rdata[BLK_W-1:LEN_W];
    assign small_cap_eff = (cfg.small_cap > SMALL_DEPTH_CAP) ? SMALL_DEPTH_CAP : cfg.small_cap;
    assign large_cap_eff = (cfg.large_cap > LARGE_DEPTH_CAP) ? LARGE_DEPTH_CAP : cfg.large_cap;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        cand_next         = cand_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        sel_global_next   = sel_global_reg;
        act_next          = act_reg;
        res_next          = res_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !rsp_ready;
        live_next         = live_reg;
        small_count_next  = small_count_reg;
        large_count_next  = large_count_reg;
        global_count_next = global_count_reg;
        pool_count_next   = pool_count_reg;
        fresh_next        = fresh_reg;
        q_pop       = 1'b0;
        blk_we      = 1'b0;
        blk_waddr   = cand_reg;
        blk_wdata   = {tid, len_reg};
        blk_raddr   = cand_reg;
        small_we    = 1'b0;
        small_waddr = '0;
        small_wdata = cur_reg.req.block_handle;
        small_raddr = '0;
        large_we    = 1'b0;
        large_waddr = '0;
        large_wdata = list_rdata;
        large_raddr = large_addr(tid, idx_reg[LCAP_W-1:0]);
        glob_we     = 1'b0;
        glob_waddr  = idx_reg[GLOBAL_ADDR_W-1:0];
        glob_wdata  = list_rdata;
        glob_raddr  = idx_reg[GLOBAL_ADDR_W-1:0];
        pool_we     = 1'b0;
        pool_waddr  = pool_count_reg[HANDLE_W-1:0];
        pool_wdata  = cur_reg.req.block_handle;
        pool_raddr  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_entry;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (cur_reg.kind)
                    KIND_ALLOC_SMALL:
                    begin
                        act_next = ACT_SMALL;
                        if (small_count_reg[tid] != '0)
                        begin
                            small_count_next[tid] = small_count_reg[tid] - 1'b1;
                            small_raddr = small_addr(tid, small_count_reg[tid] - 1'b1);
                            state_next  = ST_SPOP;
                        end
                        else
                        begin
                            len_next   = LEN_W'(cfg.small_limit);
                            state_next = ST_NEW;
                        end
                    end
                    KIND_ALLOC_LARGE:
                    begin
                        if (large_count_reg[tid] != '0)
                        begin
                            sel_global_next = 1'b0;
                            idx_next        = IDX_W'(large_count_reg[tid]);
                            cnt_next        = IDX_W'(large_count_reg[tid]);
                            state_next      = ST_SCAN_RD;
                        end
                        else if (global_count_reg != '0)
                        begin
                            sel_global_next = 1'b1;
                            idx_next        = IDX_W'(global_count_reg);
                            cnt_next        = IDX_W'(global_count_reg);
                            state_next      = ST_SCAN_RD;
                        end
                        else
                        begin
                            len_next   = cur_reg.req.req_size;
                            state_next = ST_NEW;
                        end
                    end
                    KIND_FREE_NULL:
                    begin
                        res_next   = '{'0, '0, ACT_IGNORED, ERR_NONE};
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        if (!live_reg[cur_reg.req.block_handle])
                        begin
                            res_next = '{cur_reg.req.block_handle, '0, ACT_IGNORED, ERR_INVALID};
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            blk_raddr  = cur_reg.req.block_handle;
                            state_next = ST_FREAD;
                        end
                    end
                endcase
            end
            ST_SPOP:
            begin
                cand_next  = small_rdata;
                blk_raddr  = small_rdata;
                state_next = ST_SLEN;
            end
            ST_SLEN:
            begin
                len_next   = blk_len;
                state_next = ST_TAKE;
            end
            ST_SCAN_RD:
            begin
                large_raddr = large_addr(tid, idx_reg[LCAP_W-1:0] - 1'b1);
                glob_raddr  = idx_reg[GLOBAL_ADDR_W-1:0] - 1'b1;
                state_next  = ST_SCAN_H;
            end
            ST_SCAN_H:
            begin
                cand_next  = list_rdata;
                blk_raddr  = list_rdata;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (blk_len >= cur_reg.req.req_size)
                begin
                    len_next = blk_len;
                    act_next = sel_global_reg ? ACT_GLOBAL : ACT_LOCAL;
                    if (sel_global_reg)
                    begin
                        global_count_next = global_count_reg - 1'b1;
                    end
                    else
                    begin
                        large_count_next[tid] = large_count_reg[tid] - 1'b1;
                    end
                    if (idx_reg < cnt_reg)
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ST_TAKE;
                    end
                end
                else if (idx_reg == IDX_W'(1))
                begin
                    if (!sel_global_reg && global_count_reg != '0)
                    begin
                        sel_global_next = 1'b1;
                        idx_next        = IDX_W'(global_count_reg);
                        cnt_next        = IDX_W'(global_count_reg);
                        state_next      = ST_SCAN_RD;
                    end
                    else
                    begin
                        len_next   = cur_reg.req.req_size;
                        state_next = ST_NEW;
                    end
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                large_raddr = large_addr(tid, idx_reg[LCAP_W-1:0] + 1'b1);
                glob_raddr  = idx_reg[GLOBAL_ADDR_W-1:0] + 1'b1;
                state_next  = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                large_waddr = large_addr(tid, idx_reg[LCAP_W-1:0]);
                large_we    = !sel_global_reg;
                glob_we     = sel_global_reg;
                idx_next    = idx_reg + 1'b1;
                state_next  = ((idx_reg + IDX_W'(2)) < cnt_reg) ? ST_SHIFT_RD : ST_TAKE;
            end
            ST_TAKE:
            begin
                live_next[cand_reg] = 1'b1;
                blk_we     = (act_reg == ACT_GLOBAL);
                res_next   = '{cand_reg, len_reg, act_reg, ERR_NONE};
                state_next = ST_DONE;
            end
            ST_NEW:
            begin
                if (pool_count_reg != '0)
                begin
                    pool_count_next = pool_count_reg - 1'b1;
                    pool_raddr      = pool_count_next[HANDLE_W-1:0];
                    state_next      = ST_NPOP;
                end
                else if (!fresh_reg[POOL_W-1])
                begin
                    cand_next  = fresh_reg[HANDLE_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                    state_next = ST_NWR;
                end
                else
                begin
                    res_next   = '{'0, '0, ACT_NEW, ERR_NO_HANDLE};
                    state_next = ST_DONE;
                end
            end
            ST_NPOP:
            begin
                cand_next  = pool_rdata;
                state_next = ST_NWR;
            end
            ST_NWR:
            begin
                blk_we              = 1'b1;
                live_next[cand_reg] = 1'b1;
                res_next   = '{cand_reg, len_reg, ACT_NEW, ERR_NONE};
                state_next = ST_DONE;
            end
            ST_FREAD:
            begin
                live_next[cur_reg.req.block_handle] = 1'b0;
                state_next = ST_DONE;
                if (blk_len > LEN_W'(cfg.small_limit))
                begin
                    if (large_count_reg[blk_owner] < large_cap_eff)
                    begin
                        large_we    = 1'b1;
                        large_waddr = large_addr(blk_owner, large_count_reg[blk_owner]);
                        large_wdata = cur_reg.req.block_handle;
                        large_count_next[blk_owner] = large_count_reg[blk_owner] + 1'b1;
                        res_next = '{cur_reg.req.block_handle, blk_len, ACT_KEPT, ERR_NONE};
                    end
                    else if (global_count_reg < GCOUNT_W'(GLOBAL_DEPTH))
                    begin
                        glob_we           = 1'b1;
                        glob_waddr        = global_count_reg[GLOBAL_ADDR_W-1:0];
                        glob_wdata        = cur_reg.req.block_handle;
                        global_count_next = global_count_reg + 1'b1;
                        res_next = '{cur_reg.req.block_handle, blk_len, ACT_TO_GLOBAL,
                                     ERR_NONE};
                    end
                    else
                    begin
                        if (!pool_count_reg[POOL_W-1])
                        begin
                            pool_we         = 1'b1;
                            pool_count_next = pool_count_reg + 1'b1;
                        end
                        res_next = '{cur_reg.req.block_handle, blk_len, ACT_RELEASED,
                                     ERR_GLOBAL_FULL};
                    end
                end
                else
                begin
                    if (small_count_reg[blk_owner] < small_cap_eff)
                    begin
                        small_we    = 1'b1;
                        small_waddr = small_addr(blk_owner, small_count_reg[blk_owner]);
                        small_count_next[blk_owner] = small_count_reg[blk_owner] + 1'b1;
                        res_next = '{cur_reg.req.block_handle, blk_len, ACT_KEPT, ERR_NONE};
                    end
                    else
                    begin
                        if (!pool_count_reg[POOL_W-1])
                        begin
                            pool_we         = 1'b1;
                            pool_count_next = pool_count_reg + 1'b1;
                        end
                        res_next = '{cur_reg.req.block_handle, blk_len, ACT_RELEASED,
                                     ERR_NONE};
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        cand_reg       <= cand_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        sel_global_reg <= sel_global_next;
        act_reg        <= act_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            live_reg         <= '0;
            small_count_reg  <= '{default: '0};
            large_count_reg  <= '{default: '0};
            global_count_reg <= '0;
            pool_count_reg   <= '0;
            fresh_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            live_reg         <= live_next;
            small_count_reg  <= small_count_next;
            large_count_reg  <= large_count_next;
            global_count_reg <= global_count_next;
            pool_count_reg   <= pool_count_next;
            fresh_reg        <= fresh_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/thread_cached_block_allocator.sv -----
//  Channel   Direction   Handshake               Word
//  req       in          req_valid / req_ready   tcba_pkg::req_t
//  rsp       out         rsp_valid / rsp_ready   tcba_pkg::rsp_t
//  cfg       in          cfg_we                  cfg_index, cfg_data
//
// A two-word queue takes requests while the sequencer works; one request is executed at a time.
// A large allocate tests list entries one at a time, from the top of the list down, each by a
// registered read of the list memory followed by the block table read; a hit removes the entry
// and shifts the entries above it down by one place.
// Reset is asynchronous and needs no clearing pass; liveness bits clear at once.
// A stalled response holds in the output register while the queue keeps filling.
`default_nettype none
module thread_cached_block_allocator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire tcba_pkg::req_t                     req_word,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output tcba_pkg::rsp_t                          rsp_word,
    input  wire logic                               cfg_we,
    input  wire logic [tcba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tcba_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tcba_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_limit <= SLIM_W'(1024);
            cfg_reg.small_cap   <= SCAP_W'(20);
            cfg_reg.large_cap   <= LCAP_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMALL_LIMIT: cfg_reg.small_limit <= cfg_data[SLIM_W-1:0];
                CFG_SMALL_CAP:   cfg_reg.small_cap   <= cfg_data[SCAP_W-1:0];
                CFG_LARGE_CAP:   cfg_reg.large_cap   <= cfg_data[LCAP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tcba_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
        .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry)
    );

    tcba_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
    );
endmodule
`default_nettype wire

// ----- rtl/tcba_checker.sv -----
`default_nettype none
`include "thread_cached_block_allocator_assert.svh"
module tcba_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire tcba_pkg::rsp_t rsp_word
);
    import tcba_pkg::*;

    `TCBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "response word changed while stalled")
    `TCBA_ASSERT_NOW(a_invalid_free, rsp_valid && rsp_word.error_code == ERR_INVALID, rsp_word.action == ACT_IGNORED && rsp_word.out_len == '0, "invalid free with wrong action or length")
    `TCBA_ASSERT_NOW(a_no_handle, rsp_valid && rsp_word.error_code == ERR_NO_HANDLE, rsp_word.action == ACT_NEW && rsp_word.out_handle == '0 && rsp_word.out_len == '0, "out of handles word malformed")
    `TCBA_ASSERT_NOW(a_global_full, rsp_valid && rsp_word.error_code == ERR_GLOBAL_FULL, rsp_word.action == ACT_RELEASED, "global full without release")
endmodule

bind thread_cached_block_allocator tcba_checker u_tcba_checker (.*);
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
module tb;
    import tcba_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_word = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_word;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SMALL_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    thread_cached_block_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the allocator state.
    logic [31:0] lim_small;
    int          cap_small;
    int          cap_large;
    logic [31:0] blk_len   [MAX_BLOCKS];
    int          blk_owner [MAX_BLOCKS];
    bit          blk_live  [MAX_BLOCKS];
    int          small_stk [THREADS][SMALL_DEPTH];
    int          small_cnt [THREADS];
    int          large_lst [THREADS][LARGE_DEPTH];
    int          large_cnt [THREADS];
    int          glob_lst  [GLOBAL_DEPTH];
    int          glob_cnt;
    int          pool_stk  [MAX_BLOCKS];
    int          pool_cnt;
    int          fresh_next;

    req_t pending_words[$];
    rsp_t expected_words[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  req_took = 1'b0;
    bit  rsp_took = 1'b0;
    int  req_gap = 0;
    int  rsp_stall = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_taken = 1'b0;

    function automatic int take_local(int t, logic [31:0] need);
        int h;
        for (int i = large_cnt[t]; i > 0; i--)
        begin
            h = large_lst[t][i-1];
            if (blk_len[h] >= need)
            begin
                for (int j = i - 1; j + 1 < large_cnt[t]; j++)
                    large_lst[t][j] = large_lst[t][j+1];
                large_cnt[t]--;
                return h;
            end
        end
        return -1;
    endfunction

    function automatic int take_global(logic [31:0] need);
        int h;
        for (int i = glob_cnt; i > 0; i--)
        begin
            h = glob_lst[i-1];
            if (blk_len[h] >= need)
            begin
                for (int j = i - 1; j + 1 < glob_cnt; j++)
                    glob_lst[j] = glob_lst[j+1];
                glob_cnt--;
                return h;
            end
        end
        return -1;
    endfunction

    function automatic int grab_handle();
        if (pool_cnt > 0)
        begin
            pool_cnt--;
            return pool_stk[pool_cnt];
        end
        if (fresh_next < MAX_BLOCKS)
        begin
            fresh_next++;
            return fresh_next - 1;
        end
        return -1;
    endfunction

    function automatic rsp_t serve(req_t r);
        rsp_t        o;
        int          t;
        int          h;
        int          cap;
        logic [31:0] len;
        o = '0;
        t = int'(r.thread_id) % THREADS;
        h = int'(r.block_handle);
        if (r.req_type == REQ_ALLOC)
        begin
            if (r.req_size <= lim_small)
            begin
                if (small_cnt[t] > 0)
                begin
                    small_cnt[t]--;
                    h = small_stk[t][small_cnt[t]];
                    blk_live[h] = 1'b1;
                    o.out_handle = h[7:0];
                    o.out_len = blk_len[h];
                    o.action = ACT_SMALL;
                    return o;
                end
                len = lim_small;
            end
            else
            begin
                h = take_local(t, r.req_size);
                if (h >= 0)
                begin
                    blk_live[h] = 1'b1;
                    o.out_handle = h[7:0];
                    o.out_len = blk_len[h];
                    o.action = ACT_LOCAL;
                    return o;
                end
                h = take_global(r.req_size);
                if (h >= 0)
                begin
                    blk_live[h] = 1'b1;
                    blk_owner[h] = t;
                    o.out_handle = h[7:0];
                    o.out_len = blk_len[h];
                    o.action = ACT_GLOBAL;
                    return o;
                end
                len = r.req_size;
            end
            h = grab_handle();
            o.action = ACT_NEW;
            if (h < 0)
            begin
                o.error_code = ERR_NO_HANDLE;
                return o;
            end
            blk_len[h] = len;
            blk_owner[h] = t;
            blk_live[h] = 1'b1;
            o.out_handle = h[7:0];
            o.out_len = len;
            return o;
        end
        o.action = ACT_IGNORED;
        if (!r.handle_present)
            return o;
        o.out_handle = r.block_handle;
        if (!blk_live[h])
        begin
            o.error_code = ERR_INVALID;
            return o;
        end
        t = blk_owner[h] % THREADS;
        len = blk_len[h];
        blk_live[h] = 1'b0;
        o.out_len = len;
        if (len > lim_small)
        begin
            cap = (cap_large < LARGE_DEPTH) ? cap_large : LARGE_DEPTH;
            if (large_cnt[t] < cap)
            begin
                large_lst[t][large_cnt[t]] = h;
                large_cnt[t]++;
                o.action = ACT_KEPT;
            end
            else if (glob_cnt < GLOBAL_DEPTH)
            begin
                glob_lst[glob_cnt] = h;
                glob_cnt++;
                o.action = ACT_TO_GLOBAL;
            end
            else
            begin
                if (pool_cnt < MAX_BLOCKS)
                begin
                    pool_stk[pool_cnt] = h;
                    pool_cnt++;
                end
                o.action = ACT_RELEASED;
                o.error_code = ERR_GLOBAL_FULL;
            end
        end
        else
        begin
            cap = (cap_small < SMALL_DEPTH) ? cap_small : SMALL_DEPTH;
            if (small_cnt[t] < cap)
            begin
                small_stk[t][small_cnt[t]] = h;
                small_cnt[t]++;
                o.action = ACT_KEPT;
            end
            else
            begin
                if (pool_cnt < MAX_BLOCKS)
                begin
                    pool_stk[pool_cnt] = h;
                    pool_cnt++;
                end
                o.action = ACT_RELEASED;
            end
        end
        return o;
    endfunction

    function automatic int pick_gap();
        int k;
        if (no_idle)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Sampling, prediction, checking and watchdog.
    always @(posedge clk)
    begin
        rsp_t want;
        req_took = rst_n && req_valid && req_ready;
        rsp_took = rst_n && rsp_valid && rsp_ready;
        if (req_took)
            expected_words.push_back(serve(req_word));
        if (rsp_took)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: handle %0d len %0d action %0d error %0d",
                             rsp_word.out_handle, rsp_word.out_len, rsp_word.action,
                             rsp_word.error_code);
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_word.out_handle != want.out_handle || rsp_word.out_len != want.out_len
                    || rsp_word.action != want.action
                    || rsp_word.error_code != want.error_code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h %0d len %0d act %0d err %0d, got h %0d len %0d act %0d err %0d",
                                 want.out_handle, want.out_len, want.action, want.error_code,
                                 rsp_word.out_handle, rsp_word.out_len, rsp_word.action,
                                 rsp_word.error_code);
                end
            end
        end
        if (req_took || rsp_took || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Request driver.
    always @(negedge clk)
    begin
        logic nxt_valid;
        req_t nxt_word;
        nxt_valid = req_valid;
        nxt_word = req_word;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (!req_valid || req_took)
        begin
            nxt_valid = 1'b0;
            if (req_gap > 0)
                req_gap--;
            else if (pending_words.size() > 0)
            begin
                nxt_word = pending_words.pop_front();
                nxt_valid = 1'b1;
                req_gap = pick_gap();
            end
        end
        req_valid <= nxt_valid;
        req_word <= nxt_word;
    end

    // Response acceptor, with one long hold-off on request.
    always @(negedge clk)
    begin
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (rst_n)
        begin
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_stall = 300;
            end
            if (rsp_stall > 0)
                rsp_stall--;
            else
            begin
                nxt_ready = 1'b1;
                if (rsp_took || rsp_valid)
                    rsp_stall = pick_gap();
            end
        end
        rsp_ready <= nxt_ready;
    end

    function automatic req_t mk_alloc(int t, logic [31:0] sz);
        req_t r;
        r.req_type = REQ_ALLOC;
        r.thread_id = t[TID_W-1:0];
        r.req_size = sz;
        r.handle_present = 1'($urandom);
        r.block_handle = 8'($urandom);
        return r;
    endfunction

    function automatic req_t mk_free(int h, bit present);
        req_t r;
        r.req_type = REQ_FREE;
        r.thread_id = 3'($urandom);
        r.req_size = $urandom;
        r.handle_present = present;
        r.block_handle = h[7:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_size();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return $urandom_range(0, lim_small);
        if (k < 8)
            return lim_small + $urandom_range(1, 3000);
        if (k == 8)
            return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endfunction

    task automatic wait_room();
        while (pending_words.size() > 8)
            @(negedge clk);
    endtask

    task automatic feed_random(int n, int free_pct);
        int live[$];
        int k;
        for (int i = 0; i < n; i++)
        begin
            wait_room();
            live.delete();
            for (int h = 0; h < MAX_BLOCKS; h++)
                if (blk_live[h])
                    live.push_back(h);
            k = $urandom_range(0, 99);
            if (k >= free_pct + (live.size() > 150 ? 25 : 0))
                pending_words.push_back(mk_alloc($urandom_range(0, 7), rand_size()));
            else if (k % 10 == 0)
                pending_words.push_back(mk_free($urandom, 1'b0));
            else if (k % 10 == 1 || live.size() == 0)
                pending_words.push_back(mk_free($urandom, 1'b1));
            else
                pending_words.push_back(mk_free(live[$urandom_range(0, live.size() - 1)],
                                                1'b1));
        end
    endtask

    task automatic free_all_live();
        for (int h = 0; h < MAX_BLOCKS; h++)
            if (blk_live[h])
            begin
                wait_room();
                pending_words.push_back(mk_free(h, 1'b1));
            end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        if (idx == CFG_SMALL_LIMIT)
            lim_small = val & 32'hFFFF;
        else if (idx == CFG_SMALL_CAP)
            cap_small = val & 32'h1F;
        else if (idx == CFG_LARGE_CAP)
            cap_large = val & 32'hF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int lim, int scap, int lcap);
        write_reg(CFG_SMALL_LIMIT, lim);
        write_reg(CFG_SMALL_CAP, scap);
        write_reg(CFG_LARGE_CAP, lcap);
    endtask

    initial
    begin
        lim_small = 1024;
        cap_small = 20;
        cap_large = 10;
        for (int h = 0; h < MAX_BLOCKS; h++)
            blk_live[h] = 1'b0;
        for (int t = 0; t < THREADS; t++)
        begin
            small_cnt[t] = 0;
            large_cnt[t] = 0;
        end
        glob_cnt = 0;
        pool_cnt = 0;
        fresh_next = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: size edges, both classes, cache reuse, null and invalid frees.
        pending_words.push_back(mk_alloc(0, 32'd0));
        pending_words.push_back(mk_alloc(7, 32'd1024));
        pending_words.push_back(mk_alloc(7, 32'd1025));
        pending_words.push_back(mk_alloc(3, 32'hFFFF_FFFF));
        pending_words.push_back(mk_free(0, 1'b1));
        pending_words.push_back(mk_free(1, 1'b1));
        pending_words.push_back(mk_free(2, 1'b1));
        pending_words.push_back(mk_free(3, 1'b1));
        pending_words.push_back(mk_free(3, 1'b1));
        pending_words.push_back(mk_free(255, 1'b1));
        pending_words.push_back(mk_free(0, 1'b0));
        pending_words.push_back(mk_alloc(0, 32'd5));
        pending_words.push_back(mk_alloc(7, 32'd1));
        pending_words.push_back(mk_alloc(7, 32'd1030));
        pending_words.push_back(mk_alloc(5, 32'd2000));
        pending_words.push_back(mk_alloc(0, 32'd10));
        pending_words.push_back(mk_alloc(1, 32'hFFFF_FFFF));
        pending_words.push_back(mk_free(2, 1'b1));
        pending_words.push_back(mk_free(4, 1'b1));
        drain();

        set_all(0, 0, 0);
        feed_random(70, 45);
        drain();

        set_all(65535, 31, 15);
        no_idle = 1'b1;
        feed_random(70, 45);
        drain();
        no_idle = 1'b0;

        // Overflow the shared list: no local caching for large blocks.
        set_all(16, 3, 0);
        free_all_live();
        for (int i = 0; i < 75; i++)
        begin
            wait_room();
            pending_words.push_back(mk_alloc(i % 8, 32'd1000 + i));
        end
        drain();
        free_all_live();
        feed_random(40, 45);
        drain();

        // Run out of handles, then give everything back.
        set_all(1024, 20, 10);
        for (int i = 0; i < 260; i++)
        begin
            wait_room();
            pending_words.push_back(mk_alloc($urandom_range(0, 7), rand_size()));
        end
        drain();
        free_all_live();
        drain();

        set_all(1, 20, 10);
        hold_request = 1'b1;
        feed_random(50, 45);
        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
